// ===== hw/rtl/dssf_pkg.sv =====
// Shared types, constants and segment code functions for the seven-segment formatter.
package dssf_pkg;

   localparam int BcdDigits     = 10;
   localparam int BcdWidth      = 4 * BcdDigits;
   localparam int ValueWidth    = 32;
   localparam int BitsPerStage  = 4;
   localparam int StageCount    = ValueWidth / BitsPerStage;
   localparam int DisplayDigits = 8;
   localparam int NegDigits     = 4;
   localparam int QueueDepth    = 2;

   localparam logic [7:0] SegBlank   = 8'h00;
   localparam logic [7:0] SegDash    = 8'h40;
   localparam logic [7:0] SegPoint   = 8'h80;
   localparam logic [7:0] SegLetterH = 8'h76;
   localparam logic [7:0] SegLetterF = 8'h71;
   localparam logic [7:0] SegLetterE = 8'h79;

   localparam logic [1:0] MsgTypeNormal = 2'd0;
   localparam logic [1:0] MsgTypeFault  = 2'd1;
   localparam logic [1:0] MsgTypePrompt = 2'd2;
   localparam logic [1:0] MsgTypeUnused = 2'd3;

   localparam logic OpNumber  = 1'b0;
   localparam logic OpMessage = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [31:0]       number_value;
      logic [1:0]        msg_type;
      logic [3:0]        msg_class;
      logic signed [15:0] msg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] digit1_segments;
      logic [7:0] digit2_segments;
      logic [7:0] digit3_segments;
      logic [7:0] digit4_segments;
      logic [7:0] digit5_segments;
      logic [7:0] digit6_segments;
      logic [7:0] digit7_segments;
      logic [6:0] digit8_segments;
   } rsp_type;

   typedef struct packed {
      logic       is_msg;
      logic       is_neg;
      logic [1:0] msg_type;
      logic [3:0] msg_class;
   } tag_type;

   typedef struct packed {
      tag_type               tag;
      logic [ValueWidth-1:0] value;
   } job_type;

   typedef struct packed {
      tag_type             tag;
      logic [BcdWidth-1:0] bcd;
   } conv_type;

   function automatic logic [7:0] digit_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = SegBlank;
      endcase
      return code;
   endfunction

   // class 10..15 shows class-10 with the point lit
   function automatic logic [7:0] class_code(input logic [3:0] cls);
      logic [7:0] code;
      if (cls >= 4'd10) begin
         code = digit_code(cls - 4'd10) | SegPoint;
      end else begin
         code = digit_code(cls);
      end
      return code;
   endfunction

   function automatic logic [7:0] letter_code(input logic [1:0] kind);
      logic [7:0] code;
      case (kind)
         MsgTypeNormal: code = SegLetterH;
         MsgTypeFault:  code = SegLetterF;
         MsgTypePrompt: code = SegLetterE;
         default:       code = SegBlank;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/dssf_front.sv =====
// Front end: accepts request words, picks the value to convert and queues the job.
module dssf_front
   import dssf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_word,
   input  logic    job_pop,
   output logic    job_valid,
   output job_type job_word
);

   job_type    mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   job_type    job_in;
   logic [15:0] mag;
   logic       do_push, do_pop;

   always_comb begin
      job_in.tag.is_msg    = (req_word.operation == OpMessage);
      job_in.tag.is_neg    = (req_word.operation == OpMessage) && req_word.msg_value[15];
      job_in.tag.msg_type  = req_word.msg_type;
      job_in.tag.msg_class = req_word.msg_class;
      mag = job_in.tag.is_neg ? (16'd0 - req_word.msg_value) : req_word.msg_value;
      job_in.value = job_in.tag.is_msg ? {16'd0, mag} : req_word.number_value;
   end

   assign full      = (count_ff == 2'(QueueDepth));
   assign job_valid = (count_ff != 2'd0);
   assign job_word  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ===== hw/rtl/dssf_bcd.sv =====
// Binary to BCD converter: shift-add-3 pipeline, four bits per stage.
module dssf_bcd
   import dssf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  job_type  in_job,
   output logic     in_pop,
   output logic     out_valid,
   output conv_type out_conv
);

   logic                  valid_ff [StageCount];
   logic [BcdWidth-1:0]   bcd_ff   [StageCount];
   logic [ValueWidth-1:0] value_ff [StageCount];
   tag_type               tag_ff   [StageCount];

   function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] bcd,
                                                 input logic [BitsPerStage-1:0] bits);
      logic [BcdWidth-1:0] acc;
      acc = bcd;
      for (int i = BitsPerStage - 1; i >= 0; i--) begin
         for (int d = 0; d < BcdDigits; d++) begin
            if (acc[4*d +: 4] >= 4'd5) begin
               acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
            end
         end
         acc = {acc[BcdWidth-2:0], bits[i]};
      end
      return acc;
   endfunction

   assign in_pop = advance && in_valid;

   for (genvar s = 0; s < StageCount; s++) begin : g_stage
      logic                  valid_in;
      logic [BcdWidth-1:0]   bcd_prev;
      logic [BcdWidth-1:0]   bcd_in;
      logic [ValueWidth-1:0] value_in;
      tag_type               tag_in;

      if (s == 0) begin : g_first
         assign valid_in = in_valid;
         assign bcd_prev = '0;
         assign value_in = in_job.value;
         assign tag_in   = in_job.tag;
      end else begin : g_next
         assign valid_in = valid_ff[s-1];
         assign bcd_prev = bcd_ff[s-1];
         assign value_in = value_ff[s-1];
         assign tag_in   = tag_ff[s-1];
      end

      assign bcd_in = dabble(bcd_prev,
                             value_in[ValueWidth-1-BitsPerStage*s -: BitsPerStage]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bcd_ff[s]   <= bcd_in;
            value_ff[s] <= value_in;
            tag_ff[s]   <= tag_in;
         end
      end
   end

   assign out_valid    = valid_ff[StageCount-1];
   assign out_conv.bcd = bcd_ff[StageCount-1];
   assign out_conv.tag = tag_ff[StageCount-1];

endmodule

// ===== hw/rtl/dssf_back.sv =====
// Back end: lays out the segment codes and holds finished words in the result queue.
module dssf_back
   import dssf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     conv_valid,
   input  conv_type conv_word,
   output logic     advance,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_word
);

   rsp_type    mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   rsp_type    rsp_in;
   logic [7:0] seg [DisplayDigits];
   logic [BcdDigits-1:0] any_hi;
   logic [NegDigits-1:0] any_neg;
   logic [3:0] dig [BcdDigits];
   logic       do_push, do_pop;

   always_comb begin
      for (int k = 0; k < BcdDigits; k++) begin
         dig[k] = conv_word.bcd[4*k +: 4];
      end
      any_hi[BcdDigits-1] = (dig[BcdDigits-1] != 4'd0);
      for (int k = BcdDigits - 2; k >= 0; k--) begin
         any_hi[k] = any_hi[k+1] || (dig[k] != 4'd0);
      end
      any_neg[NegDigits-1] = (dig[NegDigits-1] != 4'd0);
      for (int k = NegDigits - 2; k >= 0; k--) begin
         any_neg[k] = any_neg[k+1] || (dig[k] != 4'd0);
      end

      // right-aligned value, leading blanks, zero shows one 0
      for (int k = 0; k < DisplayDigits; k++) begin
         seg[DisplayDigits-1-k] = (k == 0 || any_hi[k]) ? digit_code(dig[k]) : SegBlank;
      end

      if (conv_word.tag.is_msg) begin
         seg[0] = letter_code(conv_word.tag.msg_type);
         seg[1] = class_code(conv_word.tag.msg_class);
         seg[2] = SegDash;
         if (conv_word.tag.is_neg) begin
            seg[DisplayDigits-1-NegDigits] = SegDash;
            for (int k = 0; k < NegDigits; k++) begin
               seg[DisplayDigits-1-k] = any_neg[k] ? digit_code(dig[k]) : SegBlank;
            end
         end
      end

      rsp_in.digit1_segments = seg[0];
      rsp_in.digit2_segments = seg[1];
      rsp_in.digit3_segments = seg[2];
      rsp_in.digit4_segments = seg[3];
      rsp_in.digit5_segments = seg[4];
      rsp_in.digit6_segments = seg[5];
      rsp_in.digit7_segments = seg[6];
      rsp_in.digit8_segments = seg[7][6:0];
   end

   assign advance  = (count_ff != 2'(QueueDepth));
   assign empty    = (count_ff == 2'd0);
   assign rsp_word = mem_ff[rd_ptr_ff];
   assign do_push  = advance && conv_valid;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== hw/rtl/decimal_seven_segment_formatter_top.sv =====
// Decimal seven-segment formatter, top level.
// Takes one request word per cycle while the input queue is not full and returns one word
// of eight segment codes for it, in order. A pushed word passes through the two-word input
// queue, the binary to BCD pipeline stages (four bits of the 32-bit value per stage) and
// the two-word result queue before it can be popped.
// Sustained rate is one word per cycle while the consumer pops every cycle; the BCD
// pipeline advances as a whole and holds whenever the result queue is full.
module decimal_seven_segment_formatter_top
   import dssf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_word,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_word
);

   logic     job_valid;
   job_type  job_word;
   logic     job_pop;
   logic     advance;
   logic     conv_valid;
   conv_type conv_word;

   dssf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .job_pop   (job_pop),
      .job_valid (job_valid),
      .job_word  (job_word)
   );

   dssf_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (job_valid),
      .in_job    (job_word),
      .in_pop    (job_pop),
      .out_valid (conv_valid),
      .out_conv  (conv_word)
   );

   dssf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .conv_valid (conv_valid),
      .conv_word  (conv_word),
      .advance    (advance),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word)
   );

endmodule
